// ----- hw/rtl/sha256_pkg.sv -----
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic load_byte;
    logic start_block;
    logic pad_start;
    logic pad_step;
    logic len_load;
    logic init_chain;
    logic out_shift;
  } dp_cmd_t;

  typedef struct packed {
    logic        rounds_done;
    logic        buf_full;
    logic [5:0]  fill;
  } dp_status_t;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- hw/rtl/sha256_ctrl.sv -----
`timescale 1ns / 1ps
module sha256_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_present_i,
  input  logic                  in_last_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            out_idx_o,
  output sha256_pkg::dp_cmd_t   cmd_o,
  input  sha256_pkg::dp_status_t sts_i
);

  typedef enum logic [2:0] {
    StIdle, StByteRound, StPadFill, StPadRound, StLenStart, StLenRound, StOut
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic       last_q, last_d;
  logic       acc;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_idx_o   = idx_q;
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    last_d  = last_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (acc) begin
          last_d = in_last_i;
          cmd_o.load_byte = in_present_i;
          if (in_present_i && sts_i.fill == 6'd63) begin
            cmd_o.start_block = 1'b1;
            state_d = StByteRound;
          end else if (in_last_i) begin
            state_d = StPadFill;
          end
        end
      end
      StByteRound: begin
        if (sts_i.rounds_done) begin
          state_d = last_q ? StPadFill : StIdle;
        end
      end
      StPadFill: begin
        cmd_o.pad_start = 1'b1;
        if (sts_i.fill > 6'd55) begin
          cmd_o.start_block = 1'b1;
          state_d = StPadRound;
        end else begin
          cmd_o.len_load = 1'b1;
          cmd_o.start_block = 1'b1;
          state_d = StLenRound;
        end
      end
      StPadRound: begin
        if (sts_i.rounds_done) begin
          cmd_o.pad_step = 1'b1;
          cmd_o.len_load = 1'b1;
          state_d = StLenStart;
        end
      end
      // chain words settle before the length block starts
      StLenStart: begin
        cmd_o.start_block = 1'b1;
        state_d = StLenRound;
      end
      StLenRound: begin
        if (sts_i.rounds_done) begin
          idx_d = '0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          cmd_o.out_shift = 1'b1;
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.init_chain = 1'b1;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept during output");
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> idx_q == 3'd0) else $error("index not cleared");
  a_wrap_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && idx_q == 3'd7) |=> in_ready_o)
    else $error("no return to idle");
`endif

endmodule

// ----- hw/rtl/sha256_dp.sv -----
`timescale 1ns / 1ps
module sha256_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             byte_i,
  input  sha256_pkg::dp_cmd_t    cmd_i,
  output sha256_pkg::dp_status_t sts_o,
  output logic [31:0]            digest_o
);

  typedef logic [31:0] w_t;

  w_t          h_q [8];
  w_t          v_q [8];
  w_t          w_q [16];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [6:0]  rnd_q;
  logic        busy_q;
  logic [5:0]  bptr_q;

  w_t   wnew, t1, t2, s0, s1, x2, x15;
  logic [5:0] r6;

  assign r6  = rnd_q[5:0];
  assign x2  = w_q[14];
  assign x15 = w_q[1];
  assign s0  = sha256_pkg::rotr(x15, 7) ^ sha256_pkg::rotr(x15, 18) ^ (x15 >> 3);
  assign s1  = sha256_pkg::rotr(x2, 17) ^ sha256_pkg::rotr(x2, 19) ^ (x2 >> 10);
  assign wnew = (rnd_q < 7'd16) ? w_q[0] : (s1 + w_q[9] + s0 + w_q[0]);
  assign t1 = v_q[7] + (sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
            ^ sha256_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + sha256_pkg::RoundK[r6] + wnew;
  assign t2 = (sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
            ^ sha256_pkg::rotr(v_q[0], 22))
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign sts_o.rounds_done = busy_q && rnd_q == 7'd64;
  assign sts_o.buf_full    = (fill_q == 6'd63);
  assign sts_o.fill        = fill_q;
  assign digest_o          = h_q[0];

  // w_q is a 16-word window: bytes shift in at w_q[15], rounds read w_q[0]
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      w_q[15] <= {w_q[15][23:0], byte_i};
    end else if (cmd_i.pad_start || cmd_i.pad_step) begin
      // realign partial data, append 0x80 (pad_start) or clear all (pad_step)
      for (int i = 0; i < 16; i++) begin
        for (int b = 0; b < 4; b++) begin
          if (cmd_i.pad_step) begin
            w_q[i][31-8*b -: 8] <= 8'h00;
          end else if ((i * 4 + b) < int'(fill_q)) begin
            w_q[i][31-8*b -: 8] <=
              w_q[(i*4+b+64-int'(fill_q))/4 % 16][31-8*((i*4+b+64-int'(fill_q))%4) -: 8];
          end else if ((i * 4 + b) == int'(fill_q)) begin
            w_q[i][31-8*b -: 8] <= sha256_pkg::PadByte;
          end else begin
            w_q[i][31-8*b -: 8] <= 8'h00;
          end
        end
      end
      if (cmd_i.len_load) begin
        w_q[14] <= bits_q[63:32];
        w_q[15] <= bits_q[31:0];
      end
    end else if (busy_q && rnd_q < 7'd64) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitH[i];
      fill_q <= '0;
      bits_q <= '0;
      rnd_q  <= '0;
      busy_q <= 1'b0;
      bptr_q <= '0;
    end else begin
      if (cmd_i.load_byte) begin
        fill_q <= fill_q + 6'd1;
        bits_q <= bits_q + 64'd8;
      end
      if (cmd_i.start_block) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end else if (busy_q) begin
        if (rnd_q == 7'd64) begin
          busy_q <= 1'b0;
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        end else begin
          rnd_q <= rnd_q + 7'd1;
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
        end
      end
      if (cmd_i.out_shift) begin
        for (int i = 0; i < 7; i++) h_q[i] <= h_q[i+1];
        h_q[7] <= h_q[0];
      end
      if (cmd_i.init_chain) begin
        for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitH[i];
        fill_q <= '0;
        bits_q <= '0;
      end
      bptr_q <= fill_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_rnd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rnd_q <= 7'd64) else $error("round overrun");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !cmd_i.start_block |-> !cmd_i.load_byte) else $error("byte during rounds");
  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.init_chain) |-> bptr_q == $past(fill_q)) else $error("fill mismatch");
`endif

endmodule

// ----- hw/rtl/sha256_stream_hash_unit.sv -----
`timescale 1ns / 1ps
// channel | dir | tdata                         | tuser         | tlast
// s_axis  | in  | [7:0] data_byte               | byte_present  | end_of_message
// m_axis  | out | [31:0] digest_word, [34:32] word_index, zero fill | -  | final_word
// A byte is taken while the unit is idle; the 64th byte of a block starts a
// compression on the single round unit. The last item adds padding: a fill
// step and one or two blocks (a restart step between two), then eight output
// words, one per accepted handshake.
// rst_ni clears length, fill and loads the initial chain words.
// Input is held off while a block compresses or the digest is being read out.
module sha256_stream_hash_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word, word_index, zero fill
  output logic        m_axis_tlast    // final_word
);

  sha256_pkg::dp_cmd_t    cmd;
  sha256_pkg::dp_status_t sts;
  logic [2:0]             idx;
  logic [31:0]            dig;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i   (s_axis_tvalid),
    .in_present_i (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_idx_o    (idx),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  sha256_dp u_dp (
    .clk_i, .rst_ni,
    .byte_i   (s_axis_tdata),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .digest_o (dig)
  );

  assign m_axis_tdata = {5'd0, idx, dig};
  assign m_axis_tlast = (idx == 3'd7);

endmodule

// ----- dv/sha256_stream_hash_unit_tb.sv -----
`timescale 1ns / 1ps
module sha256_stream_hash_unit_tb;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } digest_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  sha256_stream_hash_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  byte_req_t   byte_q[$];
  digest_res_t digest_q[$];
  int          err_cnt = 0;
  bit          calm = 1'b0;
  bit          hold_src = 1'b0;
  bit          stall_go = 1'b0;
  bit          sink_hold = 1'b0;

  sha256_pkg::word_t hash_h[8];
  logic [7:0] msg_blk[64];
  logic [5:0] blk_fill;
  logic [63:0] bit_len;

  function automatic sha256_pkg::word_t rr(sha256_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_init();
    for (int i = 0; i < 8; i++) hash_h[i] = sha256_pkg::InitH[i];
    for (int i = 0; i < 64; i++) msg_blk[i] = '0;
    blk_fill = '0;
    bit_len = '0;
  endfunction

  function automatic void hash_block();
    sha256_pkg::word_t w[64];
    sha256_pkg::word_t v[8];
    sha256_pkg::word_t t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_blk[4*i], msg_blk[4*i+1], msg_blk[4*i+2], msg_blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[i] + w[i];
      t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endfunction

  function automatic void hash_feed(byte_req_t r);
    digest_res_t d;
    if (r.byte_present) begin
      msg_blk[blk_fill] = r.data_byte;
      bit_len += 64'd8;
      blk_fill += 6'd1;
      if (blk_fill == 0) hash_block();
    end
    if (!r.end_of_message) return;
    msg_blk[blk_fill] = sha256_pkg::PadByte;
    for (int i = int'(blk_fill) + 1; i < 64; i++) msg_blk[i] = '0;
    if (blk_fill > 55) begin
      hash_block();
      for (int i = 0; i < 64; i++) msg_blk[i] = '0;
    end
    for (int i = 0; i < 8; i++) msg_blk[56+i] = bit_len[63-8*i -: 8];
    hash_block();
    for (int i = 0; i < 8; i++) begin
      d.digest_word = hash_h[i];
      d.word_index = 3'(i);
      d.final_word = (i == 7);
      digest_q.push_back(d);
    end
    hash_init();
  endfunction

  task automatic report(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  task automatic push_msg(int len, bit tail_empty, bit rnd);
    byte_req_t r;
    for (int i = 0; i < len; i++) begin
      r.data_byte = rnd ? 8'($urandom) : 8'(i * 37);
      r.byte_present = 1'b1;
      r.end_of_message = !tail_empty && (i == len - 1);
      byte_q.push_back(r);
    end
    if (tail_empty || len == 0) begin
      r.data_byte = 8'($urandom);
      r.byte_present = 1'b0;
      r.end_of_message = 1'b1;
      byte_q.push_back(r);
    end
  endtask

  // driver
  int src_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() > 0 && !hold_src) begin
          s_axis_tvalid <= 1'b1;
          {s_axis_tdata, s_axis_tuser, s_axis_tlast} <= byte_q[0];
          hash_feed(byte_q.pop_front());
          if (!calm && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 4);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver stall
  initial begin
    wait (stall_go);
    sink_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  // monitor
  int sink_gap = 0;
  always @(posedge clk_i) begin
    digest_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_q.size() == 0) begin
          report("unexpected", m_axis_tdata, '0);
        end else begin
          want = digest_q.pop_front();
          if (m_axis_tdata[31:0] !== want.digest_word)
            report("digest_word", 40'(m_axis_tdata[31:0]), 40'(want.digest_word));
          if (m_axis_tdata[34:32] !== want.word_index)
            report("word_index", 40'(m_axis_tdata[34:32]), 40'(want.word_index));
          if (m_axis_tdata[39:35] !== '0)
            report("fill", 40'(m_axis_tdata[39:35]), '0);
          if (m_axis_tlast !== want.final_word)
            report("final_word", 40'(m_axis_tlast), 40'(want.final_word));
        end
      end
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) sink_gap <= $urandom_range(1, 4);
      end
    end
  end

  initial begin
    int n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    hash_init();
    // directed: empty, no-op item, boundary lengths, an all-ones byte
    push_msg(0, 1'b1, 1'b0);
    byte_q.push_back('{8'hff, 1'b0, 1'b0});
    push_msg(3, 1'b0, 1'b0);
    byte_q.push_back('{8'hff, 1'b1, 1'b0});
    byte_q.push_back('{8'h00, 1'b1, 1'b1});
    push_msg(55, 1'b0, 1'b1);
    push_msg(56, 1'b0, 1'b1);
    push_msg(64, 1'b0, 1'b1);
    push_msg(64, 1'b1, 1'b1);
    while (byte_q.size() > 0 || digest_q.size() > 0) @(posedge clk_i);
    // long receiver stall while input keeps coming
    stall_go = 1'b1;
    push_msg(2, 1'b0, 1'b1);
    push_msg(70, 1'b0, 1'b1);
    while (byte_q.size() > 0 || digest_q.size() > 0) @(posedge clk_i);
    n = 0;
    while (n < 130) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 130) : $urandom_range(0, 12);
      if ($urandom_range(0, 7) == 0) byte_q.push_back('{8'($urandom), 1'b0, 1'b0});
      push_msg(len, $urandom_range(0, 3) == 0, 1'b1);
      n += len + 1;
      if (n > 90) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        while (byte_q.size() > 0) @(posedge clk_i);
        hold_src = 1'b1;
        while (digest_q.size() > 0) @(posedge clk_i);
        hold_src = 1'b0;
      end
    end
    while (byte_q.size() > 0 || digest_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("sha256_stream_hash_unit_tb: clean");
    end else begin
      $display("sha256_stream_hash_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("sha256_stream_hash_unit_tb: errors");
    $finish;
  end

endmodule
